### rtl/a2i32_pkg.sv
// Shared types, codes and character helpers for the ASCII to int32 parser.
package a2i32_pkg;

  // Parse phase codes
  localparam logic [2:0] PH_SKIP   = 3'd0;
  localparam logic [2:0] PH_SIGN   = 3'd1;
  localparam logic [2:0] PH_ZERO   = 3'd2;
  localparam logic [2:0] PH_XSEEN  = 3'd3;
  localparam logic [2:0] PH_DIGITS = 3'd4;

  localparam logic [15:0] MAX_OFFSET = 16'hFFFF;
  localparam logic [5:0]  RADIX_RESET = 6'd10;
  localparam logic [6:0]  NO_DIGIT = 7'd99;

  localparam logic [31:0] INT32_MAX_MAG = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_LIMIT_MAG = 32'h8000_0000;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] LC_BIAS  = 8'h57;  // 'a' - 10
  localparam logic [7:0] UC_BIAS  = 8'h37;  // 'A' - 10

  typedef struct packed {
    logic [2:0]  phase;
    logic        negative;
    logic [31:0] magnitude;
    logic [5:0]  active_base;
    logic [15:0] position;
    logic        clamped;
    logic        seen_digit;
    logic        done;
  } state_t;

  // parser state after reset: idle until a word with first
  localparam state_t STATE_RESET = '{
    phase:       PH_SKIP,
    negative:    1'b0,
    magnitude:   32'd0,
    active_base: 6'd0,
    position:    16'd0,
    clamped:     1'b0,
    seen_digit:  1'b0,
    done:        1'b1
  };

  typedef struct packed {
    logic        got_digits;
    logic        overflow;
    logic [15:0] end_offset;
    logic signed [31:0] value;
  } result_t;

  function automatic logic [6:0] digit_value(input logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      t = c - CH_ZERO;
    end else if (c >= CH_LA && c <= CH_LZ) begin
      t = c - LC_BIAS;
    end else if (c >= CH_UA && c <= CH_UZ) begin
      t = c - UC_BIAS;
    end else begin
      t = {1'b0, NO_DIGIT};
    end
    return t[6:0];
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

endpackage

### rtl/ascii_to_int32_parser_top.sv
// Streaming strtol-style parser: ASCII characters in, at most one signed 32-bit result per string out.
// Path: the character that ends the number goes through the input register and the step logic
//   into the result register, which drives m_axis.
// Throughput: one character word per cycle; input stalls only while a new result meets a
//   full result register that m_axis is not taking.
// Reset: both valids cleared, radix 10, parser idle until a word with first (tuser) set.
module ascii_to_int32_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,

  // character stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] ch
  input  logic        s_axis_tuser,   // [0] first: starts a new string
  input  logic        s_axis_tlast,   // last character of the string

  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [31:0] value, [47:32] end_offset, [48] overflow,
                                      // [49] got_digits, [55:50] zero

  // radix register write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [5:0]  cfg_data_i
);

  logic [5:0] radix_q;

  // input register
  logic       in_valid_q;
  logic [7:0] in_ch_q;
  logic       in_first_q;
  logic       in_last_q;

  // parser state and result register
  a2i32_pkg::state_t  st_q;
  a2i32_pkg::state_t  st_d;
  logic               res_valid;
  a2i32_pkg::result_t res_d;
  logic               out_valid_q;
  a2i32_pkg::result_t out_res_q;

  logic advance;

  // step fires when the result register can take a word (or the word is not needed)
  assign advance       = in_valid_q && (!res_valid || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= a2i32_pkg::RADIX_RESET;
    end else if (cfg_valid_i) begin
      radix_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_ch_q    <= s_axis_tdata;
      in_first_q <= s_axis_tuser;
      in_last_q  <= s_axis_tlast;
    end
  end

  a2i32_step u_step (
    .st_i        (st_q),
    .ch_i        (in_ch_q),
    .first_i     (in_first_q),
    .last_i      (in_last_q),
    .radix_i     (radix_q),
    .st_o        (st_d),
    .res_valid_o (res_valid),
    .res_o       (res_d)
  );

  // parse state: idle (done) after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= a2i32_pkg::STATE_RESET;
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_res_q.got_digits, out_res_q.overflow,
                          out_res_q.end_offset, out_res_q.value};

endmodule

### rtl/a2i32_step.sv
// One-character parse step: next parser state and optional result word.
module a2i32_step (
  input  a2i32_pkg::state_t  st_i,
  input  logic [7:0]         ch_i,
  input  logic               first_i,
  input  logic               last_i,
  input  logic [5:0]         radix_i,
  output a2i32_pkg::state_t  st_o,
  output logic               res_valid_o,
  output a2i32_pkg::result_t res_o
);

  a2i32_pkg::state_t cur;
  a2i32_pkg::state_t nx;

  logic [6:0]  dval;
  logic        start_zero;
  logic [5:0]  start_base;
  logic [5:0]  dig_base;
  logic [38:0] dig_next;
  logic [31:0] limit;
  logic        dig_reject;
  logic        dig_over;
  logic        take;
  logic        start;
  logic        term;
  logic [15:0] endv;
  logic [15:0] p;

  // first clears the string state before the character is looked at
  always_comb begin
    cur = st_i;
    if (first_i) begin
      cur = '0;
      cur.phase = a2i32_pkg::PH_SKIP;
    end
  end

  assign dval       = a2i32_pkg::digit_value(ch_i);
  assign start_zero = ((radix_i == 6'd0) || (radix_i == 6'd16)) && (ch_i == a2i32_pkg::CH_ZERO);
  assign start_base = (radix_i == 6'd0) ? 6'd10 : radix_i;
  assign dig_base   = ((cur.phase == a2i32_pkg::PH_SKIP) || (cur.phase == a2i32_pkg::PH_SIGN))
                      ? start_base : cur.active_base;

  // digit accumulate: one 32x6 multiply-add and a limit compare
  assign dig_next   = 39'(cur.magnitude) * 39'(dig_base) + 39'(dval);
  assign limit      = cur.negative ? a2i32_pkg::NEG_LIMIT_MAG : a2i32_pkg::INT32_MAX_MAG;
  assign dig_over   = dig_next > 39'(limit);
  assign dig_reject = (dig_base < 6'd2) || (dig_base > 6'd36) || (dval >= 7'(dig_base));

  assign p = cur.position;

  always_comb begin
    nx          = cur;
    take        = 1'b0;
    start       = 1'b0;
    term        = 1'b0;
    endv        = 16'd0;
    res_valid_o = 1'b0;
    if (!cur.done) begin
      unique case (cur.phase)
        a2i32_pkg::PH_SKIP: begin
          if (a2i32_pkg::is_space(ch_i)) begin
            nx.phase = a2i32_pkg::PH_SKIP;
          end else if (ch_i == a2i32_pkg::CH_MINUS) begin
            nx.negative = 1'b1;
            nx.phase    = a2i32_pkg::PH_SIGN;
          end else if (ch_i == a2i32_pkg::CH_PLUS) begin
            nx.phase = a2i32_pkg::PH_SIGN;
          end else begin
            start = 1'b1;
          end
        end
        a2i32_pkg::PH_SIGN: begin
          start = 1'b1;
        end
        a2i32_pkg::PH_ZERO: begin
          if (ch_i == a2i32_pkg::CH_LX || ch_i == a2i32_pkg::CH_UX) begin
            nx.active_base = 6'd16;
            nx.phase       = a2i32_pkg::PH_XSEEN;
          end else begin
            nx.phase = a2i32_pkg::PH_DIGITS;
            take     = 1'b1;
          end
        end
        a2i32_pkg::PH_XSEEN: begin
          if (dval < 7'd16) begin
            nx.phase = a2i32_pkg::PH_DIGITS;
            take     = 1'b1;
          end else begin
            // bare prefix: the number ends just past the zero
            term = 1'b1;
            endv = p - 16'd1;
          end
        end
        default: begin
          take = 1'b1;
        end
      endcase

      if (start) begin
        if (start_zero) begin
          nx.seen_digit  = 1'b1;
          nx.active_base = (radix_i == 6'd0) ? 6'd8 : 6'd16;
          nx.phase       = a2i32_pkg::PH_ZERO;
        end else begin
          nx.active_base = start_base;
          nx.phase       = a2i32_pkg::PH_DIGITS;
          take           = 1'b1;
        end
      end

      if (take) begin
        if (dig_reject) begin
          term = 1'b1;
        end else begin
          nx.seen_digit = 1'b1;
          if (!cur.clamped) begin
            if (dig_over) begin
              nx.clamped   = 1'b1;
              nx.magnitude = limit;
            end else begin
              nx.magnitude = dig_next[31:0];
            end
          end
        end
      end

      if (term && (nx.phase != a2i32_pkg::PH_XSEEN)) begin
        endv = p;
      end

      nx.position = (p >= a2i32_pkg::MAX_OFFSET) ? a2i32_pkg::MAX_OFFSET : p + 16'd1;

      if (!term && last_i) begin
        term = 1'b1;
        endv = (nx.phase == a2i32_pkg::PH_XSEEN) ? nx.position - 16'd1 : nx.position;
      end

      if (term) begin
        nx.done     = 1'b1;
        res_valid_o = 1'b1;
      end
    end
  end

  assign st_o = nx;

  assign res_o.value      = nx.negative ? $signed(32'd0 - nx.magnitude) : $signed(nx.magnitude);
  assign res_o.end_offset = nx.seen_digit ? endv : 16'd0;
  assign res_o.overflow   = nx.clamped;
  assign res_o.got_digits = nx.seen_digit;

endmodule

### sim/int32_parse_checker.sv
// Checker for the ASCII to int32 parser: predicts each parse result and compares it on m_axis.
module int32_parse_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,
  input  logic        s_tuser_i,
  input  logic        s_tlast_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [55:0] m_tdata_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [5:0]  cfg_data_i,
  output int          pending_o,
  output int          errors_o
);

  // parser state as the block should hold it
  logic [5:0]  radix_r;
  logic [2:0]  phase_r;
  logic        neg_r;
  logic [31:0] mag_r;
  logic [5:0]  base_r;
  logic [15:0] pos_r;
  logic        clamp_r;
  logic        saw_digit_r;
  logic        idle_r;

  a2i32_pkg::result_t parsed_q[$];
  a2i32_pkg::result_t want_r;
  a2i32_pkg::result_t got_r;
  int                 fail_cnt;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    fail_cnt++;
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  function automatic logic [6:0] char_weight(input logic [7:0] c);
    logic [7:0] w;
    w = {1'b0, a2i32_pkg::NO_DIGIT};
    if (c >= "0" && c <= "9") begin
      w = c - "0";
    end else if (c >= "a" && c <= "z") begin
      w = c - "a" + 8'd10;
    end else if (c >= "A" && c <= "Z") begin
      w = c - "A" + 8'd10;
    end
    return w[6:0];
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == " ") || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // one character in the digit phase; 1 means it ends the number
  function automatic logic accum_digit(input logic [7:0] c);
    logic [6:0]  d;
    logic [63:0] lim;
    logic [63:0] nxt;
    d = char_weight(c);
    if (base_r < 6'd2 || base_r > 6'd36 || d >= {1'b0, base_r}) return 1'b1;
    saw_digit_r = 1'b1;
    if (clamp_r) return 1'b0;
    lim = neg_r ? 64'h8000_0000 : 64'h7FFF_FFFF;
    nxt = {32'd0, mag_r} * 64'(base_r) + 64'(d);
    if (nxt > lim) begin
      clamp_r = 1'b1;
      mag_r = lim[31:0];
    end else begin
      mag_r = nxt[31:0];
    end
    return 1'b0;
  endfunction

  // first character after blanks and sign; base is picked here
  function automatic logic start_number(input logic [7:0] c);
    if ((radix_r == 6'd0 || radix_r == 6'd16) && c == "0") begin
      saw_digit_r = 1'b1;
      base_r = (radix_r == 6'd0) ? 6'd8 : 6'd16;
      phase_r = a2i32_pkg::PH_ZERO;
      return 1'b0;
    end
    base_r = (radix_r == 6'd0) ? 6'd10 : radix_r;
    phase_r = a2i32_pkg::PH_DIGITS;
    return accum_digit(c);
  endfunction

  function automatic logic parse_step(input logic [7:0] c, input logic first,
                                      input logic last, output a2i32_pkg::result_t r);
    logic [15:0] p;
    logic [15:0] endv;
    logic        term;
    endv = 16'd0;
    term = 1'b0;
    r = '0;
    if (first) begin
      phase_r = a2i32_pkg::PH_SKIP;
      neg_r = 1'b0;
      mag_r = 32'd0;
      base_r = 6'd0;
      pos_r = 16'd0;
      clamp_r = 1'b0;
      saw_digit_r = 1'b0;
      idle_r = 1'b0;
    end
    if (idle_r) return 1'b0;
    p = pos_r;
    case (phase_r)
      a2i32_pkg::PH_SKIP: begin
        if (is_blank(c)) begin
        end else if (c == "-") begin
          neg_r = 1'b1;
          phase_r = a2i32_pkg::PH_SIGN;
        end else if (c == "+") begin
          phase_r = a2i32_pkg::PH_SIGN;
        end else begin
          term = start_number(c);
        end
      end
      a2i32_pkg::PH_SIGN: term = start_number(c);
      a2i32_pkg::PH_ZERO: begin
        if (c == "x" || c == "X") begin
          base_r = 6'd16;
          phase_r = a2i32_pkg::PH_XSEEN;
        end else begin
          phase_r = a2i32_pkg::PH_DIGITS;
          term = accum_digit(c);
        end
      end
      a2i32_pkg::PH_XSEEN: begin
        if (char_weight(c) < 7'd16) begin
          phase_r = a2i32_pkg::PH_DIGITS;
          term = accum_digit(c);
        end else begin
          // bare 0x: the number is the single '0'
          term = 1'b1;
          endv = p - 16'd1;
        end
      end
      default: term = accum_digit(c);
    endcase
    if (term && phase_r != a2i32_pkg::PH_XSEEN) endv = p;
    pos_r = (p == a2i32_pkg::MAX_OFFSET) ? p : p + 16'd1;
    if (!term && last) begin
      term = 1'b1;
      endv = (phase_r == a2i32_pkg::PH_XSEEN) ? pos_r - 16'd1 : pos_r;
    end
    if (!term) return 1'b0;
    idle_r = 1'b1;
    r.value = neg_r ? (32'd0 - mag_r) : mag_r;
    r.end_offset = saw_digit_r ? endv : 16'd0;
    r.overflow = clamp_r;
    r.got_digits = saw_digit_r;
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_r = a2i32_pkg::RADIX_RESET;
      phase_r = a2i32_pkg::PH_SKIP;
      neg_r = 1'b0;
      mag_r = 32'd0;
      base_r = 6'd0;
      pos_r = 16'd0;
      clamp_r = 1'b0;
      saw_digit_r = 1'b0;
      idle_r = 1'b1;
      parsed_q.delete();
      fail_cnt = 0;
      pending_o <= 0;
      errors_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) radix_r = cfg_data_i;
      if (s_tvalid_i && s_tready_i) begin
        if (parse_step(s_tdata_i, s_tuser_i, s_tlast_i, want_r)) parsed_q.push_back(want_r);
      end
      if (m_tvalid_i && m_tready_i) begin
        got_r = a2i32_pkg::result_t'(m_tdata_i[49:0]);
        if (parsed_q.size() == 0) begin
          report("unexpected result word", 64'(m_tdata_i), 64'd0);
        end else begin
          want_r = parsed_q.pop_front();
          if (got_r.value !== want_r.value)
            report("value", 64'(got_r.value), 64'(want_r.value));
          if (got_r.end_offset !== want_r.end_offset)
            report("end_offset", 64'(got_r.end_offset), 64'(want_r.end_offset));
          if (got_r.overflow !== want_r.overflow)
            report("overflow", 64'(got_r.overflow), 64'(want_r.overflow));
          if (got_r.got_digits !== want_r.got_digits)
            report("got_digits", 64'(got_r.got_digits), 64'(want_r.got_digits));
          if (m_tdata_i[55:50] !== 6'd0)
            report("tdata padding", 64'(m_tdata_i[55:50]), 64'd0);
        end
      end
      pending_o <= parsed_q.size();
      errors_o <= fail_cnt;
    end
  end

endmodule

### sim/tb.sv
// Testbench top for the ASCII to int32 parser: stimulus, result-side flow control and verdict.
module tb;

  localparam int CYCLE_LIMIT = 500_000;
  localparam int HOLD_CYCLES = 300;    // long receiver hold-off to back up the pipe
  localparam int RAND_WORDS  = 650;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [5:0]  cfg_data_i;

  int pending;
  int errors;
  int cycle_cnt = 0;
  int results_taken = 0;
  int rand_words = 0;
  int phase_words;
  int phase_no = 0;
  logic in_idle = 1'b1;
  logic out_idle = 1'b1;
  logic [5:0] rad;
  logic [7:0] text_q[$];

  always #5 clk_i = ~clk_i;

  ascii_to_int32_parser_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  int32_parse_checker chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .s_tlast_i   (s_axis_tlast),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  // watchdog: a hung handshake ends the run here
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("ascii_to_int32_parser_top regression: fail");
      $finish;
    end
  end

  // one character word; valid is left high so a back-to-back word needs no second assignment
  task automatic send_char(input logic [7:0] c, input logic first, input logic last);
    int gap;
    gap = in_idle ? $urandom_range(0, 17) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tuser  <= first;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // sends the queued string: first on its opening word, last (if asked) on its final one
  task automatic send_text(input logic with_last);
    int n;
    n = text_q.size();
    for (int i = 0; i < n; i++)
      send_char(text_q[i], i == 0, with_last && (i == n - 1));
    text_q.delete();
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  // radix is only written with nothing in flight: drain results, then let the pipe settle
  task automatic set_radix(input logic [5:0] r);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= r;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [7:0] digit_char(input int v);
    if (v < 10) return 8'("0" + v);
    return 8'(($urandom_range(0, 1) ? "a" : "A") + v - 10);
  endfunction

  function automatic logic [7:0] blank_char();
    int k;
    k = $urandom_range(8, 13);
    return (k == 8) ? 8'h20 : 8'(k);
  endfunction

  // mostly well-formed numbers with random content; some noise and bare prefixes
  task automatic build_number(input logic [5:0] r);
    int base;
    int mode;
    logic [31:0] m;
    logic [7:0] tmp_q[$];
    base = (r >= 6'd2 && r <= 6'd36) ? int'(r) : 10;
    repeat ($urandom_range(0, 3)) text_q.push_back(blank_char());
    case ($urandom_range(0, 2))
      1: text_q.push_back("+");
      2: text_q.push_back("-");
      default: ;
    endcase
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      repeat ($urandom_range(1, 4)) text_q.push_back(8'($urandom_range(0, 255)));
    end else if (mode <= 2) begin
      // leading zero, maybe a 0x/0X prefix, maybe hex digits after it
      text_q.push_back("0");
      if ($urandom_range(0, 3) != 0) text_q.push_back($urandom_range(0, 1) ? "x" : "X");
      repeat ($urandom_range(0, 4)) text_q.push_back(digit_char($urandom_range(0, 15)));
    end else if (mode == 3) begin
      // magnitudes around the int32 limits, spelled in the current base
      case ($urandom_range(0, 3))
        0: m = 32'h7FFF_FFFF;
        1: m = 32'h8000_0000;
        2: m = 32'h8000_0001;
        default: m = $urandom;
      endcase
      do begin
        tmp_q.push_front(digit_char(m % base));
        m = m / base;
      end while (m != 0);
      foreach (tmp_q[i]) text_q.push_back(tmp_q[i]);
    end else begin
      repeat ($urandom_range(1, 12)) text_q.push_back(digit_char($urandom_range(0, base - 1)));
    end
    if ($urandom_range(0, 4) < 2) text_q.push_back(8'($urandom_range(0, 255)));
  endtask

  // result side: random stalls per word, idle-free stretches, and two long hold-offs
  initial begin
    int n;
    m_axis_tready = 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      n = out_idle ? $urandom_range(0, 17) : 0;
      if (n != 0) begin
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      results_taken++;
      if (results_taken % 8 == 0) out_idle = ($urandom_range(0, 3) != 0);
      if (results_taken == 20 || results_taken == 60) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'd0;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = 6'd0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, radix 10 from reset
    send_char(8'hFF, 1'b0, 1'b1);            // parser idle: word without first is dropped
    push_text("\t-7");
    text_q.push_back(8'h00);                 // NUL ends the number, not counted
    send_text(1'b1);
    push_text("+");                          // sign only: no digits
    send_text(1'b1);
    push_text("12");                         // dropped by a restart
    send_text(1'b0);
    push_text("9");
    send_text(1'b1);

    set_radix(6'd0);                         // auto base from prefix
    push_text("0x");                         // bare hex prefix
    send_text(1'b1);
    push_text("0X1f");
    send_text(1'b1);
    push_text("07");                         // leading zero selects octal
    send_text(1'b1);

    set_radix(6'd36);
    push_text("-zzzzzz");                    // clamps to the most negative value
    send_text(1'b1);

    set_radix(6'd63);                        // out-of-range base takes no digit
    push_text("5");
    send_text(1'b1);

    // random part: one radix per phase, extremes first
    while (rand_words < RAND_WORDS) begin
      case (phase_no)
        0: rad = 6'd10;
        1: rad = 6'd0;
        2: rad = 6'd2;
        3: rad = 6'd36;
        4: rad = 6'd16;
        5: rad = 6'd1;
        6: rad = 6'd63;
        default: begin
          case ($urandom_range(0, 9))
            0: rad = 6'd0;
            1: rad = 6'd2;
            2: rad = 6'd8;
            3: rad = 6'd16;
            4: rad = 6'd36;
            5: rad = 6'd1;
            6: rad = 6'($urandom_range(37, 63));
            default: rad = 6'($urandom_range(0, 36));
          endcase
        end
      endcase
      phase_no++;
      set_radix(rad);
      phase_words = 0;
      while (phase_words < 60) begin
        in_idle = ($urandom_range(0, 3) != 0);
        build_number(rad);
        phase_words += text_q.size();
        rand_words += text_q.size();
        send_text($urandom_range(0, 9) != 0);   // some strings are cut off by a restart
        if ($urandom_range(0, 9) == 0)
          send_char(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
      end
    end

    // drain, allow a late stray word to show up, then decide
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("ascii_to_int32_parser_top regression: pass");
    end else begin
      $display("ascii_to_int32_parser_top regression: fail");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/a2i32_pkg.sv
rtl/a2i32_step.sv
rtl/ascii_to_int32_parser_top.sv
sim/int32_parse_checker.sv
sim/tb.sv
